@@ sv/wrlb_pkg.sv @@
package wrlb_pkg;

  localparam int unsigned CountWidth = 32;

  localparam logic [13:0] MinFrameLength = 14'd42;
  localparam logic [15:0] EtherTypeIpv4  = 16'h0800;
  localparam logic [7:0]  ProtocolUdp    = 8'd17;

  localparam logic [31:0] VirtualAddressReset = 32'h0A00_0001;
  localparam logic [31:0] ServerAAddressReset = 32'h0A00_0102;
  localparam logic [31:0] ServerBAddressReset = 32'h0A00_0202;
  localparam logic [47:0] ServerAMacReset     = 48'h0200_0000_0021;
  localparam logic [47:0] ServerBMacReset     = 48'h0200_0000_0022;
  localparam logic [7:0]  WeightAReset        = 8'd5;
  localparam logic [7:0]  WeightBReset        = 8'd2;

  typedef enum logic [2:0] {
    RegVirtualAddress = 3'd0,
    RegServerAAddress = 3'd1,
    RegServerBAddress = 3'd2,
    RegServerAMac     = 3'd3,
    RegServerBMac     = 3'd4,
    RegWeightA        = 3'd5,
    RegWeightB        = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [13:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] ip_destination;
    logic [15:0] ip_header_checksum;
    logic [15:0] udp_checksum_in;
  } in_item_t;

  typedef struct packed {
    logic        action;
    logic        server_select;
    logic [47:0] new_dest_mac;
    logic [31:0] new_ip_destination;
    logic [15:0] new_ip_checksum;
    logic [15:0] new_udp_checksum;
    logic [31:0] served_count;
  } out_item_t;

endpackage

@@ sv/wrlb_csum_adjust.sv @@
module wrlb_csum_adjust import wrlb_pkg::*; (
  input  logic [15:0] check_i,
  input  logic [31:0] old_addr_i,
  input  logic [31:0] new_addr_i,
  output logic [15:0] check_o
);

  logic [15:0] check_n;
  logic [15:0] old_hi_n;
  logic [15:0] old_lo_n;
  logic [18:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] folded;

  assign check_n  = ~check_i;
  assign old_hi_n = ~old_addr_i[31:16];
  assign old_lo_n = ~old_addr_i[15:0];

  // an all-zero sum is lifted to 0xffff below, as a 0xffff0000 term (zero mod 0xffff) would
  assign sum = 19'(check_n) + 19'(old_hi_n) + 19'(old_lo_n)
             + 19'(new_addr_i[31:16]) + 19'(new_addr_i[15:0]);
  assign fold1  = 17'(sum[15:0]) + 17'(sum[18:16]);
  assign fold2  = fold1[15:0] + 16'(fold1[16]);
  assign folded = (fold2 == 16'h0000) ? 16'hFFFF : fold2;
  assign check_o = ~folded;

endmodule

@@ sv/weighted_rr_udp_load_balancer.sv @@
// Weighted round-robin load balancer for parsed UDP frame headers.
// Input channel: in_valid_i / in_stall_o carry one header item (in_item_t).
// Output channel: out_valid_o / out_stall_i carry one result item
// (out_item_t) for every header item, in order.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high, an index beyond the register list is ignored.
// Write configuration only while no item is in flight.
// Data path: an accepted item sits in the input register, and its result is
// loaded into the output register once that register is empty or being
// read, and is offered from there.
// Throughput: one item per cycle while out_stall_i is low; the rotation
// position and picked server's counter advance as a balanced result is loaded.
// Receiver stall: the result holds in the output register; the input
// register still accepts one more item, after which in_stall_o follows
// out_stall_i.
// Reset: registers take their documented reset values, rotation position
// and both counters clear, and both channels are empty.
module weighted_rr_udp_load_balancer import wrlb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  logic [31:0] virtual_address_q;
  logic [31:0] server_a_address_q;
  logic [31:0] server_b_address_q;
  logic [47:0] server_a_mac_q;
  logic [47:0] server_b_mac_q;
  logic [7:0]  weight_a_q;
  logic [7:0]  weight_b_q;

  logic                  in_valid_q;
  in_item_t              in_item_q;
  logic                  out_valid_q;
  out_item_t             out_item_q;
  out_item_t             out_item_d;
  logic [8:0]            rotation_q;
  logic [8:0]            rotation_d;
  logic [CountWidth-1:0] count_a_q;
  logic [CountWidth-1:0] count_b_q;
  logic [CountWidth-1:0] count_a_inc;
  logic [CountWidth-1:0] count_b_inc;

  logic        out_load;
  logic        in_load;
  logic        balanced;
  logic [8:0]  total;
  logic [8:0]  position;
  logic [8:0]  position_next;
  logic        pick_a;
  logic [31:0] new_ip;
  logic [15:0] ip_check;
  logic [15:0] udp_check;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      virtual_address_q  <= VirtualAddressReset;
      server_a_address_q <= ServerAAddressReset;
      server_b_address_q <= ServerBAddressReset;
      server_a_mac_q     <= ServerAMacReset;
      server_b_mac_q     <= ServerBMacReset;
      weight_a_q         <= WeightAReset;
      weight_b_q         <= WeightBReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegVirtualAddress: virtual_address_q  <= cfg_data_i[31:0];
        RegServerAAddress: server_a_address_q <= cfg_data_i[31:0];
        RegServerBAddress: server_b_address_q <= cfg_data_i[31:0];
        RegServerAMac:     server_a_mac_q     <= cfg_data_i;
        RegServerBMac:     server_b_mac_q     <= cfg_data_i;
        RegWeightA:        weight_a_q         <= cfg_data_i[7:0];
        RegWeightB:        weight_b_q         <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign out_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !out_load;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (out_load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_item_q <= in_item_i;
    end
  end

  assign balanced = (in_item_q.frame_length >= MinFrameLength)
                 && (in_item_q.ether_type == EtherTypeIpv4)
                 && (in_item_q.ip_protocol == ProtocolUdp)
                 && (in_item_q.ip_destination == virtual_address_q);

  assign total         = 9'(weight_a_q) + 9'(weight_b_q);
  assign position      = (rotation_q >= total) ? 9'd0 : rotation_q;
  assign pick_a        = position < 9'(weight_a_q);
  assign position_next = position + 9'd1;
  assign rotation_d    = (position_next >= total) ? 9'd0 : position_next;
  assign count_a_inc   = count_a_q + CountWidth'(1);
  assign count_b_inc   = count_b_q + CountWidth'(1);
  assign new_ip        = pick_a ? server_a_address_q : server_b_address_q;

  wrlb_csum_adjust u_ip_csum (
    .check_i    (in_item_q.ip_header_checksum),
    .old_addr_i (in_item_q.ip_destination),
    .new_addr_i (new_ip),
    .check_o    (ip_check)
  );

  wrlb_csum_adjust u_udp_csum (
    .check_i    (in_item_q.udp_checksum_in),
    .old_addr_i (in_item_q.ip_destination),
    .new_addr_i (new_ip),
    .check_o    (udp_check)
  );

  always_comb begin
    if (balanced) begin
      out_item_d.action             = 1'b1;
      out_item_d.server_select      = !pick_a;
      out_item_d.new_dest_mac       = pick_a ? server_a_mac_q : server_b_mac_q;
      out_item_d.new_ip_destination = new_ip;
      out_item_d.new_ip_checksum    = ip_check;
      out_item_d.new_udp_checksum   = udp_check;
      out_item_d.served_count       = pick_a ? 32'(count_a_inc) : 32'(count_b_inc);
    end else begin
      out_item_d.action             = 1'b0;
      out_item_d.server_select      = 1'b0;
      out_item_d.new_dest_mac       = 48'd0;
      out_item_d.new_ip_destination = in_item_q.ip_destination;
      out_item_d.new_ip_checksum    = in_item_q.ip_header_checksum;
      out_item_d.new_udp_checksum   = in_item_q.udp_checksum_in;
      out_item_d.served_count       = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= 9'd0;
      count_a_q  <= '0;
      count_b_q  <= '0;
    end else if (out_load && balanced) begin
      rotation_q <= rotation_d;
      if (pick_a) begin
        count_a_q <= count_a_inc;
      end else begin
        count_b_q <= count_b_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ sim/weighted_rr_udp_load_balancer_tb.sv @@
`timescale 1ns / 100ps

module weighted_rr_udp_load_balancer_tb;
  import wrlb_pkg::*;

  localparam logic [2:0] RegNone = 3'd7;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseCount = 9;
  localparam int unsigned PhaseItems = 45;

  class lb_scoreboard;
    logic [31:0] vip;
    logic [31:0] a_ip;
    logic [31:0] b_ip;
    logic [47:0] a_mac;
    logic [47:0] b_mac;
    logic [7:0] wa;
    logic [7:0] wb;
    logic [8:0] rot_pos;
    logic [CountWidth-1:0] a_cnt;
    logic [CountWidth-1:0] b_cnt;
    out_item_t due_results[$];
    int unsigned errors;

    function new();
      vip = VirtualAddressReset;
      a_ip = ServerAAddressReset;
      b_ip = ServerBAddressReset;
      a_mac = ServerAMacReset;
      b_mac = ServerBMacReset;
      wa = WeightAReset;
      wb = WeightBReset;
      rot_pos = '0;
      a_cnt = '0;
      b_cnt = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] d);
      case (idx)
        RegVirtualAddress: vip = d[31:0];
        RegServerAAddress: a_ip = d[31:0];
        RegServerBAddress: b_ip = d[31:0];
        RegServerAMac: a_mac = d;
        RegServerBMac: b_mac = d;
        RegWeightA: wa = d[7:0];
        RegWeightB: wb = d[7:0];
        default: ;
      endcase
    endfunction

    // incremental ones' complement update for an address swap
    function logic [15:0] csum_fix(logic [15:0] ck, logic [31:0] old_a, logic [31:0] new_a);
      logic [15:0] nck;
      logic [15:0] no_hi;
      logic [15:0] no_lo;
      logic [63:0] s;
      nck = ~ck;
      no_hi = ~old_a[31:16];
      no_lo = ~old_a[15:0];
      s = 64'hFFFF_0000 + nck + no_hi + no_lo + new_a[31:16] + new_a[15:0];
      while (s[63:16] != 0) s = s[15:0] + s[63:16];
      return ~s[15:0];
    endfunction

    function void note_header(in_item_t h);
      out_item_t e;
      int unsigned total;
      int unsigned pos;
      int unsigned nxt;
      logic pick_a;
      logic [31:0] new_ip;
      e = '0;
      e.new_ip_destination = h.ip_destination;
      e.new_ip_checksum = h.ip_header_checksum;
      e.new_udp_checksum = h.udp_checksum_in;
      if (h.frame_length >= MinFrameLength && h.ether_type == EtherTypeIpv4 &&
          h.ip_protocol == ProtocolUdp && h.ip_destination == vip) begin
        total = 32'(wa) + 32'(wb);
        pos = 32'(rot_pos);
        if (pos >= total) pos = 0;
        pick_a = (pos < 32'(wa));
        nxt = pos + 1;
        rot_pos = (nxt >= total) ? 9'd0 : nxt[8:0];
        if (pick_a) begin
          a_cnt = a_cnt + 1'b1;
          e.served_count = 32'(a_cnt);
          new_ip = a_ip;
          e.new_dest_mac = a_mac;
        end else begin
          b_cnt = b_cnt + 1'b1;
          e.served_count = 32'(b_cnt);
          new_ip = b_ip;
          e.new_dest_mac = b_mac;
        end
        e.action = 1'b1;
        e.server_select = !pick_a;
        e.new_ip_destination = new_ip;
        e.new_ip_checksum = csum_fix(h.ip_header_checksum, h.ip_destination, new_ip);
        e.new_udp_checksum = csum_fix(h.udp_checksum_in, h.ip_destination, new_ip);
      end
      due_results.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    task check_result(out_item_t r);
      out_item_t e;
      if (due_results.size() == 0) begin
        report("unexpected item", r.served_count, 0);
      end else begin
        e = due_results.pop_front();
        if (r.action !== e.action) report("action", r.action, e.action);
        if (r.server_select !== e.server_select)
          report("server_select", r.server_select, e.server_select);
        if (r.new_dest_mac !== e.new_dest_mac)
          report("new_dest_mac", r.new_dest_mac, e.new_dest_mac);
        if (r.new_ip_destination !== e.new_ip_destination)
          report("new_ip_destination", r.new_ip_destination, e.new_ip_destination);
        if (r.new_ip_checksum !== e.new_ip_checksum)
          report("new_ip_checksum", r.new_ip_checksum, e.new_ip_checksum);
        if (r.new_udp_checksum !== e.new_udp_checksum)
          report("new_udp_checksum", r.new_udp_checksum, e.new_udp_checksum);
        if (r.served_count !== e.served_count)
          report("served_count", r.served_count, e.served_count);
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [47:0] cfg_data_i;

  lb_scoreboard sb = new();
  int unsigned in_idle_pct = 23;
  int unsigned out_idle_pct = 48;
  int unsigned cycle_count = 0;

  weighted_rr_udp_load_balancer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_header(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  function logic [47:0] rnd48();
    return {16'($urandom()), $urandom()};
  endfunction

  function in_item_t mk_hdr(logic [13:0] len, logic [15:0] et, logic [7:0] pr,
                            logic [31:0] dst, logic [15:0] ipck, logic [15:0] udpck);
    in_item_t h;
    h.frame_length = len;
    h.ether_type = et;
    h.ip_protocol = pr;
    h.ip_destination = dst;
    h.ip_header_checksum = ipck;
    h.udp_checksum_in = udpck;
    return h;
  endfunction

  function in_item_t rand_hdr(logic [31:0] vip);
    in_item_t h;
    int unsigned r;
    r = $urandom_range(99);
    h = mk_hdr(14'($urandom_range(1500, 42)), EtherTypeIpv4, ProtocolUdp, vip,
               16'($urandom()), 16'($urandom()));
    if (r < 10) h.frame_length = 14'($urandom_range(16383, 42));
    if (r >= 70 && r < 85) begin
      case ($urandom_range(3))
        0: h.frame_length = 14'($urandom_range(41));
        1: h.ether_type = EtherTypeIpv4 ^ (16'd1 << $urandom_range(15));
        2: h.ip_protocol = ProtocolUdp ^ (8'd1 << $urandom_range(7));
        default: h.ip_destination = vip ^ (32'd1 << $urandom_range(31));
      endcase
    end else if (r >= 85) begin
      h = mk_hdr(14'($urandom()), 16'($urandom()), 8'($urandom()), $urandom(),
                 16'($urandom()), 16'($urandom()));
    end
    return h;
  endfunction

  task send_hdr(in_item_t h);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= h;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task wait_all_results();
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task write_cfg(logic [2:0] idx, logic [47:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task apply_setting(int unsigned k);
    logic [31:0] vip;
    logic [31:0] aip;
    logic [31:0] bip;
    logic [47:0] amac;
    logic [47:0] bmac;
    logic [7:0] wa;
    logic [7:0] wb;
    logic [47:0] junk;
    vip = $urandom();
    aip = $urandom();
    bip = $urandom();
    amac = rnd48();
    bmac = rnd48();
    wa = 8'($urandom_range(12));
    wb = 8'($urandom_range(12));
    junk = rnd48();
    case (k)
      1: begin
        wa = 8'd0;
        wb = 8'd0;
      end
      2: begin
        wa = 8'd255;
        wb = 8'd255;
        aip = '0;
        bip = '1;
        amac = '0;
        bmac = '1;
      end
      3: wa = 8'd0;
      4: wb = 8'd0;
      5: begin
        wa = 8'd1;
        wb = 8'd1;
        vip = '1;
      end
      7: begin
        wa = 8'd255;
        wb = 8'd1;
        vip = '0;
        aip = '1;
        bip = '0;
        amac = '1;
        bmac = '0;
      end
      default: ;
    endcase
    wait_all_results();
    write_cfg(RegVirtualAddress, {junk[15:0], vip});
    write_cfg(RegServerAAddress, {junk[31:16], aip});
    write_cfg(RegServerBAddress, {junk[47:32], bip});
    write_cfg(RegServerAMac, amac);
    write_cfg(RegServerBMac, bmac);
    write_cfg(RegWeightA, {junk[39:0], wa});
    write_cfg(RegWeightB, {junk[47:8], wb});
    write_cfg(RegNone, junk);
  endtask

  task run_directed();
    logic [31:0] vip;
    vip = VirtualAddressReset;
    send_hdr(mk_hdr(14'd42, EtherTypeIpv4, ProtocolUdp, vip, 16'h1234, 16'h5678));
    send_hdr(mk_hdr(14'd41, EtherTypeIpv4, ProtocolUdp, vip, 16'h1234, 16'h5678));
    send_hdr(mk_hdr(14'h3FFF, EtherTypeIpv4, ProtocolUdp, vip, 16'hFFFF, 16'hFFFF));
    send_hdr(mk_hdr(14'd0, EtherTypeIpv4, ProtocolUdp, vip, 16'h0000, 16'h0000));
    send_hdr(mk_hdr(14'd60, 16'h86DD, ProtocolUdp, vip, 16'hABCD, 16'h0000));
    send_hdr(mk_hdr(14'd60, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_hdr(mk_hdr(14'd60, EtherTypeIpv4, 8'd6, vip, 16'h0001, 16'h0001));
    send_hdr(mk_hdr(14'd60, EtherTypeIpv4, ProtocolUdp, vip ^ 32'd1, 16'h0F0F, 16'hF0F0));
    send_hdr(mk_hdr(14'd60, EtherTypeIpv4, ProtocolUdp, 32'd0, 16'h0F0F, 16'hF0F0));
    // zero checksums, then walk the rotation through A and into B
    send_hdr(mk_hdr(14'd64, EtherTypeIpv4, ProtocolUdp, vip, 16'h0000, 16'h0000));
    repeat (7) send_hdr(mk_hdr(14'd1500, EtherTypeIpv4, ProtocolUdp, vip,
                               16'($urandom()), 16'($urandom())));
    // both weights zero
    wait_all_results();
    write_cfg(RegWeightA, 48'd0);
    write_cfg(RegWeightB, 48'd0);
    write_cfg(RegNone, '1);
    repeat (2) send_hdr(mk_hdr(14'd100, EtherTypeIpv4, ProtocolUdp, vip,
                               16'($urandom()), 16'($urandom())));
    // leave the position beyond a shrunken rotation
    wait_all_results();
    write_cfg(RegWeightA, 48'd3);
    write_cfg(RegWeightB, 48'd4);
    repeat (5) send_hdr(mk_hdr(14'd100, EtherTypeIpv4, ProtocolUdp, vip,
                               16'($urandom()), 16'($urandom())));
    wait_all_results();
    write_cfg(RegWeightA, 48'd1);
    write_cfg(RegWeightB, 48'd1);
    repeat (2) send_hdr(mk_hdr(14'd100, EtherTypeIpv4, ProtocolUdp, vip,
                               16'($urandom()), 16'($urandom())));
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    for (int unsigned k = 0; k < PhaseCount; k++) begin
      apply_setting(k);
      if (k < 3) begin
        in_idle_pct = 23;
        out_idle_pct = 48;
      end else if (k < 6) begin
        in_idle_pct = 48;
        out_idle_pct = 23;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (k == 4 && n == 20) wait_all_results();
        send_hdr(rand_hdr(sb.vip));
      end
    end
    wait_all_results();
    repeat (5) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
